// ----- src/dcfe_pkg.sv -----
// shared types, constants and crc helper for the drive command frame encoder
`default_nettype none
package dcfe_pkg;

	localparam int unsigned FRAME_LEN = 9;
	localparam int unsigned IDX_W     = 4;

	localparam logic [7:0]  SYNC_BYTE = 8'hFF;
	localparam logic [7:0]  CMD_BYTE  = 8'h07;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	// frame byte positions in send order
	localparam logic [IDX_W-1:0] BYTE_SYNC   = 4'd0;
	localparam logic [IDX_W-1:0] BYTE_CMD    = 4'd1;
	localparam logic [IDX_W-1:0] BYTE_L_LO   = 4'd2;
	localparam logic [IDX_W-1:0] BYTE_L_HI   = 4'd3;
	localparam logic [IDX_W-1:0] BYTE_R_LO   = 4'd4;
	localparam logic [IDX_W-1:0] BYTE_R_HI   = 4'd5;
	localparam logic [IDX_W-1:0] BYTE_CTRL   = 4'd6;
	localparam logic [IDX_W-1:0] BYTE_CRC_LO = 4'd7;
	localparam logic [IDX_W-1:0] BYTE_CRC_HI = 4'd8;

	// control byte bits
	localparam int unsigned CTRL_SPD_HI = 7;
	localparam int unsigned CTRL_L_FWD  = 6;
	localparam int unsigned CTRL_SPD_LO = 5;
	localparam int unsigned CTRL_R_FWD  = 4;
	localparam int unsigned CTRL_ONE    = 3;

	typedef struct packed {
		logic [15:0] lmag;
		logic [15:0] rmag;
		logic [7:0]  ctrl;
	} cmd_entry_t;

	// one byte of crc-16/modbus, lsb first
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- src/dcfe_front.sv -----
// front end: config register, magnitude and direction, control byte build
`default_nettype none
module dcfe_front
	import dcfe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [15:0]       left_speed,
	input  wire logic [15:0]       right_speed,
	input  wire logic              q_full,
	output logic                   q_push,
	output cmd_entry_t             q_entry
);

	logic        spd_en_q;
	logic        lfwd, rfwd;
	logic [15:0] lmag, rmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_en_q <= 1'b0;
		end else if (cfg_we) begin
			spd_en_q <= cfg_data;
		end
	end

	// two's complement magnitude; most negative code stays 0x8000
	assign lfwd = ~left_speed[15];
	assign rfwd = ~right_speed[15];
	assign lmag = lfwd ? left_speed  : (~left_speed + 16'd1);
	assign rmag = rfwd ? right_speed : (~right_speed + 16'd1);

	always_comb begin
		q_entry.lmag = lmag;
		q_entry.rmag = rmag;
		q_entry.ctrl = 8'h00;
		q_entry.ctrl[CTRL_SPD_HI] = spd_en_q;
		q_entry.ctrl[CTRL_L_FWD]  = lfwd;
		q_entry.ctrl[CTRL_SPD_LO] = spd_en_q;
		q_entry.ctrl[CTRL_R_FWD]  = rfwd;
		q_entry.ctrl[CTRL_ONE]    = 1'b1;
	end

	assign in_ready = ~q_full;
	assign q_push   = in_valid & ~q_full;

endmodule
`default_nettype wire

// ----- src/dcfe_queue.sv -----
// two-entry command queue between front and back
`default_nettype none
module dcfe_queue
	import dcfe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire cmd_entry_t push_entry,
	output logic            full,
	input  wire logic       pop,
	output logic            not_empty,
	output cmd_entry_t      head
);

	cmd_entry_t  slot_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/dcfe_back.sv -----
// back end: byte serializer with running crc and output register
`default_nettype none
module dcfe_back
	import dcfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_not_empty,
	input  wire cmd_entry_t  q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       frame_byte,
	output logic             last_byte
);

	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             load;
	logic [7:0]       next_byte;

	assign load  = q_not_empty & (~out_valid_q | out_ready);
	assign q_pop = load & (idx_q == BYTE_CRC_HI);

	always_comb begin
		case (idx_q)
			BYTE_SYNC:   next_byte = SYNC_BYTE;
			BYTE_CMD:    next_byte = CMD_BYTE;
			BYTE_L_LO:   next_byte = q_head.lmag[7:0];
			BYTE_L_HI:   next_byte = q_head.lmag[15:8];
			BYTE_R_LO:   next_byte = q_head.rmag[7:0];
			BYTE_R_HI:   next_byte = q_head.rmag[15:8];
			BYTE_CTRL:   next_byte = q_head.ctrl;
			BYTE_CRC_LO: next_byte = crc_q[7:0];
			BYTE_CRC_HI: next_byte = crc_q[15:8];
			default:     next_byte = SYNC_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= BYTE_SYNC;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= (idx_q == BYTE_CRC_HI) ? BYTE_SYNC : idx_q + 4'd1;
				// crc covers command byte through control byte
				if (idx_q == BYTE_SYNC) begin
					crc_q <= CRC_INIT;
				end else if (idx_q inside {[BYTE_CMD:BYTE_CTRL]}) begin
					crc_q <= crc_update(crc_q, next_byte);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= next_byte;
			last_q <= (idx_q == BYTE_CRC_HI);
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

endmodule
`default_nettype wire

// ----- src/drive_command_frame_encoder_core.sv -----
// top level of the drive command frame encoder
//
//  channel   direction  handshake                          word
//  config    in         speed_control_enable_we            speed_control_enable
//  command   in         in_valid / in_ready                left_speed, right_speed
//  frame     out        out_valid / out_ready              frame_byte, last_byte
//
// each command word becomes nine frame words, one per cycle while out_ready is high;
// the byte serializer in the back end produces them
// a two-entry queue lets the front take the next command while a frame is still going out
// the output register holds a word under stall; the crc is updated one byte per cycle unless the output stalls
// asynchronous reset clears the flag, queue pointers and serializer state
`default_nettype none
module drive_command_frame_encoder_core
	import dcfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        speed_control_enable_we,
	input  wire logic        speed_control_enable,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] left_speed,
	input  wire logic [15:0] right_speed,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       frame_byte,
	output logic             last_byte
);

	cmd_entry_t push_entry, head;
	logic       push, full, pop, not_empty;

	dcfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (speed_control_enable_we),
		.cfg_data   (speed_control_enable),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.left_speed (left_speed),
		.right_speed(right_speed),
		.q_full     (full),
		.q_push     (push),
		.q_entry    (push_entry)
	);

	dcfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	dcfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(not_empty),
		.q_head     (head),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule
`default_nettype wire
